>>> src/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Shared widths, field layout and controller/datapath interface types for the
// multi-source reachability block.
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam int IDX_W      = 6;   // node slot field
  localparam int NB_W       = 7;   // neighbour slot field, 64 means none
  localparam int MAX_DEGREE = 6;   // neighbour fields per node beat

  // Input tdata: node_index, is_source, six neighbours, padded to 56 bits.
  localparam int IN_FIELD_W = IDX_W + 1 + MAX_DEGREE * NB_W;
  localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int IN_NB_LSB  = IDX_W + 1;

  // Output tdata: result_index, powered, padded to 8 bits.
  localparam int OUT_FIELD_W = IDX_W + 1;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [NB_W-1:0]  nb_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // write the accepted node beat
    logic seed;      // start the sweep from the present sources
    logic rd_en;     // read the adjacency entry at the pointer
    logic update;    // fold the next frontier into the reached set
    logic rep_step;  // report the slot at the pointer
    logic ptr_clr;
    logic ptr_inc;
    logic clear;     // drop the batch tables
  } msr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ptr_last;
    logic live_none;
    logic front_none;
    logic out_free;
  } msr_sts_t;

endpackage

>>> src/msr_ctrl.sv
// ----------------------------------------------------------------------------
// msr_ctrl
// Batch sequencer: load nodes, run frontier rounds, report, clear.
// ----------------------------------------------------------------------------
module msr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  msr_pkg::msr_sts_t sts_i,
  output msr_pkg::msr_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_REPORT,
    ST_CLEAR
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        if (sts_i.live_none) begin
          state_d = ST_LOAD;
        end else begin
          cmd_o.seed    = 1'b1;
          cmd_o.ptr_clr = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        if (sts_i.ptr_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // let the last read land in the next-frontier mask
        cmd_o.ptr_clr = 1'b1;
        state_d       = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = sts_i.front_none ? ST_REPORT : ST_SCAN;
      end
      ST_REPORT: begin
        if (sts_i.out_free) begin
          cmd_o.rep_step = 1'b1;
          cmd_o.ptr_inc  = 1'b1;
          if (sts_i.ptr_last) begin
            state_d = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clear   = 1'b1;
        cmd_o.ptr_clr = 1'b1;
        state_d       = ST_LOAD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/msr_datapath.sv
// ----------------------------------------------------------------------------
// msr_datapath
// Node tables, adjacency memory, reached/frontier masks and result register.
// ----------------------------------------------------------------------------
module msr_datapath #(
  parameter int NODES  = 64,
  parameter int DEGREE = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msr_pkg::msr_cmd_t cmd_i,
  output msr_pkg::msr_sts_t sts_o,
  input  msr_pkg::idx_t     in_slot_i,
  input  logic              in_src_i,
  input  msr_pkg::nb_t      in_nb_i [msr_pkg::MAX_DEGREE],
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output msr_pkg::idx_t     out_idx_o,
  output logic              out_powered_o,
  output logic              out_last_o
);

  localparam int SLOT_W = $clog2(NODES);
  localparam int ADJ_W  = DEGREE * msr_pkg::NB_W;

  typedef logic [SLOT_W-1:0] slot_t;

  logic [ADJ_W-1:0] adj_mem [NODES];
  logic [ADJ_W-1:0] adj_wr;
  logic [ADJ_W-1:0] rdata_q;

  logic [NODES-1:0] present_q, source_q, reached_q, front_q, next_q;
  logic [NODES-1:0] front_new, nb_mask;
  slot_t            ptr_q, last_q, rslot_q, wr_slot;
  logic             rvld_q, in_range, wr_en;

  logic             out_vld_q, out_pow_q, out_last_q;
  msr_pkg::idx_t    out_idx_q;

  assign in_range = {1'b0, in_slot_i} < msr_pkg::nb_t'(NODES);
  assign wr_slot  = in_slot_i[SLOT_W-1:0];
  assign wr_en    = cmd_i.load && in_range;

  always_comb begin
    adj_wr = '0;
    for (int k = 0; k < DEGREE; k++) begin
      adj_wr[k*msr_pkg::NB_W +: msr_pkg::NB_W] = in_nb_i[k];
    end
  end

  // Neighbour set of the entry just read; out-of-range values are no edge
  always_comb begin
    msr_pkg::nb_t nb;
    nb_mask = '0;
    for (int k = 0; k < DEGREE; k++) begin
      nb = rdata_q[k*msr_pkg::NB_W +: msr_pkg::NB_W];
      if (nb < msr_pkg::nb_t'(NODES)) begin
        nb_mask[nb[SLOT_W-1:0]] = 1'b1;
      end
    end
  end

  assign front_new = next_q & present_q & ~reached_q;

  assign sts_o.ptr_last   = (ptr_q == slot_t'(NODES - 1));
  assign sts_o.live_none  = ~|present_q;
  assign sts_o.front_none = ~|front_new;
  assign sts_o.out_free   = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      adj_mem[wr_slot] <= adj_wr;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= adj_mem[ptr_q];
      rslot_q <= ptr_q;
    end
    if (cmd_i.rep_step) begin
      out_idx_q  <= msr_pkg::idx_t'(ptr_q);
      out_pow_q  <= reached_q[ptr_q];
      out_last_q <= (ptr_q == last_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      source_q  <= '0;
      reached_q <= '0;
      front_q   <= '0;
      next_q    <= '0;
      last_q    <= '0;
      ptr_q     <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rvld_q <= cmd_i.rd_en;

      if (cmd_i.clear) begin
        present_q <= '0;
        source_q  <= '0;
        reached_q <= '0;
        front_q   <= '0;
        last_q    <= '0;
      end else if (wr_en) begin
        present_q[wr_slot] <= 1'b1;
        source_q[wr_slot]  <= in_src_i;
        if (wr_slot > last_q) begin
          last_q <= wr_slot;
        end
      end

      if (cmd_i.seed) begin
        reached_q <= present_q & source_q;
        front_q   <= present_q & source_q;
        next_q    <= '0;
      end else if (cmd_i.update) begin
        front_q   <= front_new;
        reached_q <= reached_q | front_new;
        next_q    <= '0;
      end else if (rvld_q && front_q[rslot_q]) begin
        next_q <= next_q | nb_mask;
      end

      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + slot_t'(1);
      end

      // skip absent slots, hold the beat while stalled
      if (cmd_i.rep_step && present_q[ptr_q]) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_idx_o     = out_idx_q;
  assign out_powered_o = out_pow_q;
  assign out_last_o    = out_last_q;

endmodule

>>> src/multi_source_reachability.sv
// ----------------------------------------------------------------------------
// multi_source_reachability
// Loads a batch of graph nodes and reports which present nodes are reachable
// from a present source node.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one node per beat (slot, source flag, neighbours);
//   tlast marks the last node of a batch. A node beat is taken every cycle
//   while the block is loading.
//   After the batch end the block runs breadth-first rounds. Each round walks
//   the adjacency memory, one slot read per cycle, then folds the new frontier
//   into the reached set; the number of rounds is the longest shortest path
//   from a source plus one (at most NODES).
//   The report then walks all NODES slots, one per cycle while the master
//   channel is not stalled, and sends one beat per present node in ascending
//   slot order; tlast marks the last of them. A stall on the master channel
//   holds the result register and the walk. A clear step then drops the
//   tables; loading resumes after it, even while the final result beat still
//   waits to be taken. A batch with no present node sends nothing.
//   Reset empties the node tables and returns the block to loading.
// ----------------------------------------------------------------------------
module multi_source_reachability #(
  parameter int NODES  = 64,
  parameter int DEGREE = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // node_index[5:0], is_source[6], neighbour_a..f[48:7] (7 bits each), zero
  input  logic [msr_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  logic                             s_axis_tlast_i,   // batch_end
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // result_index[5:0], powered[6], zero[7]
  output logic [msr_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tlast_o    // result_last
);

  msr_pkg::msr_cmd_t cmd;
  msr_pkg::msr_sts_t sts;
  msr_pkg::nb_t      in_nb [msr_pkg::MAX_DEGREE];
  msr_pkg::idx_t     out_idx;
  logic              out_powered;

  always_comb begin
    for (int k = 0; k < msr_pkg::MAX_DEGREE; k++) begin
      in_nb[k] = s_axis_tdata_i[msr_pkg::IN_NB_LSB + k*msr_pkg::NB_W +: msr_pkg::NB_W];
    end
  end

  msr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msr_datapath #(
    .NODES  (NODES),
    .DEGREE (DEGREE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_slot_i     (s_axis_tdata_i[msr_pkg::IDX_W-1:0]),
    .in_src_i      (s_axis_tdata_i[msr_pkg::IDX_W]),
    .in_nb_i       (in_nb),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_idx_o     (out_idx),
    .out_powered_o (out_powered),
    .out_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(msr_pkg::OUT_DATA_W - msr_pkg::OUT_FIELD_W){1'b0}},
                           out_powered, out_idx};

  // the batch end beat hands the block over to the sweep
  a_busy_after_end : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o
  ) else $error("input still ready after batch end");

  // while loading, only the final beat of the previous batch may be pending
  a_load_pending_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && m_axis_tvalid_o |-> m_axis_tlast_o
  ) else $error("non-final result pending during load");

endmodule

>>> dv/multi_source_reachability_tb.sv
// ----------------------------------------------------------------------------
// multi_source_reachability_tb
// Streams batches of graph nodes into the block and checks every result beat
// against a local breadth-first predictor of which present nodes are powered
// by a present source. Both stream sides idle at random, the receiver holds
// off once for a long stretch, and the sender drains the block twice.
// ----------------------------------------------------------------------------
module multi_source_reachability_tb;

  localparam int           NODES   = 64;
  localparam int           DEGREE  = msr_pkg::MAX_DEGREE;
  localparam int           LIMIT   = 2_000_000;
  localparam msr_pkg::nb_t NB_NONE = 7'd64;

  typedef struct packed {
    logic                                   last;
    msr_pkg::nb_t [msr_pkg::MAX_DEGREE-1:0] nb;      // nb[0] is neighbour_a
    logic                                   source;
    msr_pkg::idx_t                          slot;
  } node_beat_t;

  typedef struct packed {
    msr_pkg::idx_t slot;
    logic          powered;
    logic          last;
  } report_t;

  // Holds the node table of the open batch and the reports it is owed.
  class power_predictor;
    bit           present[NODES];
    bit           is_src[NODES];
    msr_pkg::nb_t adj[NODES][DEGREE];
    report_t      reports_due[$];
    int           errors;

    function int open_reports();
      return reports_due.size();
    endfunction

    function void note_node(node_beat_t n);
      logic [NODES-1:0] live, reach, front, nxt;
      int               top;
      report_t          r;
      present[n.slot] = 1'b1;
      is_src[n.slot]  = n.source;
      for (int k = 0; k < DEGREE; k++) adj[n.slot][k] = n.nb[k];
      if (!n.last) return;
      live  = '0;
      reach = '0;
      top   = -1;
      for (int s = 0; s < NODES; s++) begin
        if (present[s]) begin
          live[s]  = 1'b1;
          reach[s] = is_src[s];
          top      = s;
        end
      end
      front = reach;
      for (int rnd = 0; rnd < NODES && front != '0; rnd++) begin
        nxt = '0;
        for (int s = 0; s < NODES; s++) begin
          if (front[s]) begin
            for (int k = 0; k < DEGREE; k++) begin
              if (adj[s][k] < NODES) nxt[adj[s][k]] = 1'b1;
            end
          end
        end
        front = nxt & live & ~reach;
        reach = reach | front;
      end
      for (int s = 0; s < NODES; s++) begin
        if (present[s]) begin
          r.slot      = msr_pkg::idx_t'(s);
          r.powered   = reach[s];
          r.last      = (s == top);
          reports_due = {reports_due, r};
        end
        present[s] = 1'b0;
        is_src[s]  = 1'b0;
      end
    endfunction

    function void check_report(msr_pkg::idx_t slot, logic powered, logic last);
      report_t exp;
      if (reports_due.size() == 0) begin
        $error("result beat with nothing due: result_index %0d", slot);
        errors++;
        return;
      end
      exp = reports_due.pop_front();
      if (slot !== exp.slot) begin
        $error("result_index: expected %0d, got %0d", exp.slot, slot);
        errors++;
      end
      if (powered !== exp.powered) begin
        $error("powered: expected %0d, got %0d", exp.powered, powered);
        errors++;
      end
      if (last !== exp.last) begin
        $error("result_last: expected %0d, got %0d", exp.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_n    = 1'b0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [msr_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
  logic                           s_tlast  = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [msr_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tlast;

  power_predictor sb;
  int             tx_idle_pct  = 34;
  int             rx_idle_pct  = 57;
  int             items_sent   = 0;
  int             stall_left   = 0;
  int             cycles       = 0;
  logic           rx_hold_req  = 1'b0;
  logic           rx_hold_done = 1'b0;

  multi_source_reachability #(
    .NODES  (NODES),
    .DEGREE (DEGREE)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: check each beat, then pick tready for the next cycle.
  always @(posedge clk_i) begin
    if (rst_n && m_tvalid && m_tready) begin
      sb.check_report(m_tdata[msr_pkg::IDX_W-1:0], m_tdata[msr_pkg::IDX_W], m_tlast);
    end
    if (rx_hold_req && !rx_hold_done) begin
      stall_left   = 500;
      rx_hold_done = 1'b1;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic node_beat_t mk_node(msr_pkg::idx_t slot, logic source,
                                         msr_pkg::nb_t a, msr_pkg::nb_t b,
                                         msr_pkg::nb_t c, msr_pkg::nb_t d,
                                         msr_pkg::nb_t e, msr_pkg::nb_t f,
                                         logic last);
    node_beat_t n;
    n.slot   = slot;
    n.source = source;
    n.nb     = {f, e, d, c, b, a};
    n.last   = last;
    return n;
  endfunction

  task automatic send_node(input node_beat_t n);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(msr_pkg::IN_DATA_W - msr_pkg::IN_FIELD_W){1'b0}},
                 n.nb, n.source, n.slot};
    s_tlast  <= n.last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_node(n);
    items_sent++;
  endtask

  // Most neighbours point into the batch so that sweeps run several rounds.
  task automatic send_random_batch(input int size);
    msr_pkg::idx_t slots[$];
    node_beat_t    n;
    int            r;
    for (int i = 0; i < size; i++) begin
      if (i > 0 && $urandom_range(0, 9) == 0) begin
        slots = {slots, slots[$urandom_range(0, i - 1)]};
      end else begin
        slots = {slots, msr_pkg::idx_t'($urandom_range(0, NODES - 1))};
      end
    end
    for (int i = 0; i < size; i++) begin
      n.slot   = slots[i];
      n.source = ($urandom_range(0, 99) < 20);
      n.last   = (i == size - 1);
      for (int k = 0; k < msr_pkg::MAX_DEGREE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 55)      n.nb[k] = msr_pkg::nb_t'(slots[$urandom_range(0, size - 1)]);
        else if (r < 70) n.nb[k] = msr_pkg::nb_t'($urandom_range(0, NODES - 1));
        else if (r < 88) n.nb[k] = NB_NONE;
        else             n.nb[k] = msr_pkg::nb_t'($urandom_range(65, 127));
      end
      send_node(n);
    end
  endtask

  function automatic int pick_batch_size();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
  endfunction

  initial begin
    int order[NODES];
    int j, tmp, s;
    sb = new;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Lone source on slot 0 with a self edge.
    send_node(mk_node(0, 1, 0, NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, 1));
    // Slot 63 alone, out-of-range and absent neighbours.
    send_node(mk_node(63, 0, 63, 127, 64, 65, 100, 0, 1));
    // Overwrite a source, multi-hop through the sixth field, edges to absent slots.
    send_node(mk_node(5, 1, 6, NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, 0));
    send_node(mk_node(6, 0, 7, NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, 0));
    send_node(mk_node(7, 0, 40, NB_NONE, NB_NONE, NB_NONE, NB_NONE, 62, 0));
    send_node(mk_node(5, 0, NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, 0));
    send_node(mk_node(20, 1, 6, 127, NB_NONE, NB_NONE, NB_NONE, NB_NONE, 0));
    send_node(mk_node(33, 0, 20, NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, 0));
    send_node(mk_node(62, 0, NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, 1));
    // Sources of the previous batch must not carry over.
    send_node(mk_node(33, 0, 34, NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, 0));
    send_node(mk_node(34, 0, NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, 1));
    // All neighbour bits high, then a source fanning out to present and absent slots.
    send_node(mk_node(10, 1, 127, 127, 127, 127, 127, 127, 0));
    send_node(mk_node(11, 0, 64, 64, 64, 64, 64, 64, 0));
    send_node(mk_node(12, 1, 10, 11, 12, 13, 14, 15, 1));
    // Cycle reached from one source, plus a node that only points into it.
    send_node(mk_node(1, 1, 2, NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, 0));
    send_node(mk_node(2, 0, 3, NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, 0));
    send_node(mk_node(3, 0, 1, NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, 0));
    send_node(mk_node(4, 0, 1, NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, 1));

    while (items_sent < 120) send_random_batch(pick_batch_size());

    tx_idle_pct  = 57;
    rx_idle_pct <= 34;
    while (items_sent < 215) send_random_batch(pick_batch_size());

    tx_idle_pct  = 0;
    rx_idle_pct <= 0;
    // Drain the block completely before the hold-off.
    s_tvalid <= 1'b0;
    while (sb.open_reports() != 0) @(posedge clk_i);

    // Receiver holds off while the sender keeps pushing; input backs up.
    rx_hold_req <= 1'b1;
    send_random_batch(20);
    send_random_batch(20);

    // Full 64-slot chain from slot 0, loaded in shuffled order: deepest sweep.
    for (int i = 0; i < NODES; i++) order[i] = i;
    for (int i = NODES - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < NODES; i++) begin
      s = order[i];
      send_node(mk_node(msr_pkg::idx_t'(s), (s == 0),
                        (s == NODES - 1) ? NB_NONE : msr_pkg::nb_t'(s + 1),
                        NB_NONE, NB_NONE, NB_NONE, NB_NONE, NB_NONE, (i == NODES - 1)));
    end

    while (items_sent < 350) send_random_batch(pick_batch_size());

    s_tvalid <= 1'b0;
    while (sb.open_reports() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
src/msr_pkg.sv
src/msr_ctrl.sv
src/msr_datapath.sv
src/multi_source_reachability.sv
dv/multi_source_reachability_tb.sv
